@@ rtl/mfr_pkg.sv @@
// Shared types, constants and register codes of the mesh flood relay filter.
`timescale 1ns / 1ps
package mfr_pkg;

  localparam int unsigned SeenDepthDefault = 32;
  localparam int unsigned KeyW             = 32;
  localparam logic [15:0] BroadcastId      = 16'hFFFF;
  localparam logic [15:0] MaxDivider       = 16'd8;

  typedef enum logic [2:0] {
    REG_OWN_ID       = 3'd0,
    REG_RELAY_MODE   = 3'd1,
    REG_RESTART_CODE = 3'd2,
    REG_CONFIG_CODE  = 3'd3,
    REG_RELAY_MASK   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] origin_node;
    logic [15:0] sequence_req;
    logic [7:0]  hop_budget;
    logic [7:0]  packet_kind;
    logic [7:0]  packet_flags;
    logic [7:0]  sensor_field;
    logic [7:0]  spare_byte;
    logic [15:0] distance_field;
  } item_t;

  typedef struct packed {
    logic       forward;
    logic [7:0] forward_hops;
    logic [7:0] forward_flags;
    logic       restart_request;
    logic       config_update;
    logic       pin_update;
    logic [7:0] new_pin;
    logic       new_enable;
    logic       divider_update;
    logic [3:0] new_divider;
  } result_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic tok;
    logic hit;
  } probe_t;

endpackage

@@ rtl/mfr_stream_if.sv @@
// Valid/ready channel carrying one request payload.
`timescale 1ns / 1ps
interface mfr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/mfr_seen_cell.sv @@
// One seen-store cell: holds a key, shifts on insert, checks a passing probe.
`timescale 1ns / 1ps
module mfr_seen_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [mfr_pkg::KeyW-1:0]     key_i,
  output logic [mfr_pkg::KeyW-1:0]     key_o,
  input  logic [mfr_pkg::KeyW-1:0]     probe_key_i,
  input  mfr_pkg::probe_t              probe_i,
  output mfr_pkg::probe_t              probe_o
);
  import mfr_pkg::*;

  logic [KeyW-1:0] key_d, key_q;
  probe_t          probe_d, probe_q;

  always_comb begin
    key_d = shift_i ? key_i : key_q;
    probe_d.tok = probe_i.tok;
    probe_d.hit = probe_i.tok && (probe_i.hit || (key_q == probe_key_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      probe_q <= '0;
    end else begin
      key_q   <= key_d;
      probe_q <= probe_d;
    end
  end

  assign key_o   = key_q;
  assign probe_o = probe_q;

endmodule

@@ rtl/mesh_flood_relay_filter_top.sv @@
// Mesh flood relay filter: command decode and duplicate suppression over a cell chain.
//
//   port   | dir | carries
//   -------+-----+-------------------------------------------------
//   in_i   | in  | packet header request (item_t)
//   out_o  | out | relay and command decision (result_t)
//   cfg_i  | in  | register write (cfg_req_t), always ready
//
// A request without seen-store lookup passes through S_DONE into the output register.
// A lookup sends a probe token down the SEEN_DEPTH cells, one cell per cycle,
// and when it leaves the last cell the request moves on to S_DONE; one request is in work at a time.
// A finished result waits in the output register; the next request may enter meanwhile.
// Reset clears all stored keys to zero, the registers to their defaults, and control.
`timescale 1ns / 1ps
module mesh_flood_relay_filter_top #(
  parameter int unsigned SEEN_DEPTH = mfr_pkg::SeenDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  mfr_stream_if.sink   in_i,
  mfr_stream_if.source out_o,
  mfr_stream_if.sink   cfg_i
);
  import mfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_d, state_q;

  logic [15:0] own_id_q;
  logic        relay_mode_q;
  logic [7:0]  restart_code_q, config_code_q, relay_mask_q;

  item_t   item_q;
  logic    lookup_q, tok_start_q, hit_q;
  result_t res_q, res_d;
  logic    out_valid_q;

  cfg_req_t cfg_req;
  item_t    in_item;
  logic     in_acc, cfg_acc, lookup_in, load, shift;
  logic     addressed, restart_cmd, config_cmd, div_ok;
  logic [KeyW-1:0] probe_key;

  probe_t          probe_chain [SEEN_DEPTH+1];
  logic [KeyW-1:0] key_chain   [SEEN_DEPTH];
  logic [SEEN_DEPTH:0] tok_vec;

  assign cfg_req     = cfg_i.payload;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  assign in_item    = in_i.payload;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign lookup_in = relay_mode_q && (in_item.origin_node != own_id_q) &&
                     (in_item.hop_budget != 8'd0) &&
                     !(((in_item.origin_node == own_id_q) ||
                        (in_item.origin_node == BroadcastId)) &&
                       (in_item.packet_kind == restart_code_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q       <= '0;
      relay_mode_q   <= 1'b1;
      restart_code_q <= 8'd0;
      config_code_q  <= 8'd1;
      relay_mask_q   <= 8'd1;
    end else if (cfg_acc) begin
      case (cfg_req.index)
        REG_OWN_ID:       own_id_q       <= cfg_req.data;
        REG_RELAY_MODE:   relay_mode_q   <= cfg_req.data[0];
        REG_RESTART_CODE: restart_code_q <= cfg_req.data[7:0];
        REG_CONFIG_CODE:  config_code_q  <= cfg_req.data[7:0];
        REG_RELAY_MASK:   relay_mask_q   <= cfg_req.data[7:0];
        default: ;
      endcase
    end
  end

  // seen store: cell 0 takes the new key, the oldest key drops off the far end
  assign probe_key      = {item_q.origin_node, item_q.sequence_req};
  assign probe_chain[0] = '{tok: tok_start_q, hit: 1'b0};

  for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
    assign tok_vec[i] = probe_chain[i].tok;
    if (i == SEEN_DEPTH - 1) begin : g_last
      mfr_seen_cell u_cell (
        .clk_i,
        .rst_ni,
        .shift_i     (shift),
        .key_i       ((i == 0) ? probe_key : key_chain[(i == 0) ? 0 : i - 1]),
        .key_o       (key_chain[i]),
        .probe_key_i (probe_key),
        .probe_i     (probe_chain[i]),
        .probe_o     (probe_chain[i+1])
      );
    end else begin : g_mid
      mfr_seen_cell u_cell (
        .clk_i,
        .rst_ni,
        .shift_i     (shift),
        .key_i       ((i == 0) ? probe_key : key_chain[(i == 0) ? 0 : i - 1]),
        .key_o       (key_chain[i]),
        .probe_key_i (probe_key),
        .probe_i     (probe_chain[i]),
        .probe_o     (probe_chain[i+1])
      );
    end
  end
  assign tok_vec[SEEN_DEPTH] = probe_chain[SEEN_DEPTH].tok;

  assign load  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign shift = load && lookup_q && !hit_q;

  always_comb begin
    addressed   = (item_q.origin_node == own_id_q) || (item_q.origin_node == BroadcastId);
    restart_cmd = addressed && (item_q.packet_kind == restart_code_q);
    config_cmd  = addressed && (item_q.packet_kind == config_code_q) && !restart_cmd;
    div_ok      = (item_q.distance_field != 16'd0) && (item_q.distance_field <= MaxDivider);
    res_d                 = '0;
    res_d.restart_request = restart_cmd;
    if (config_cmd) begin
      res_d.config_update  = 1'b1;
      res_d.pin_update     = (item_q.sensor_field != 8'd0);
      res_d.new_pin        = item_q.sensor_field;
      res_d.new_enable     = (item_q.spare_byte != 8'd0);
      res_d.divider_update = div_ok;
      res_d.new_divider    = div_ok ? item_q.distance_field[3:0] : 4'd0;
    end
    if (lookup_q && !hit_q) begin
      res_d.forward       = 1'b1;
      res_d.forward_hops  = item_q.hop_budget - 8'd1;
      res_d.forward_flags = item_q.packet_flags | relay_mask_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = lookup_in ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (probe_chain[SEEN_DEPTH].tok) state_d = S_DONE;
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lookup_q    <= 1'b0;
      tok_start_q <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tok_start_q <= in_acc && lookup_in;
      if (in_acc) begin
        lookup_q <= lookup_in;
        hit_q    <= 1'b0;
      end
      if ((state_q == S_WALK) && probe_chain[SEEN_DEPTH].tok) begin
        hit_q <= probe_chain[SEEN_DEPTH].hit;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_item;
    if (load)   res_q  <= res_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = res_q;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one probe token in the seen chain");

  a_token_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vec != '0) |-> (state_q == S_WALK))
    else $error("probe token outside a lookup");

  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && lookup_in) |=> (tok_start_q && (state_q == S_WALK)))
    else $error("lookup request did not launch a probe");

  a_restart_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.restart_request && (res_q.forward || res_q.config_update)))
    else $error("restart result carries other actions");

  a_fwd_hops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.forward) |-> (res_q.forward_hops != 8'hFF))
    else $error("forwarded request with zero hop budget");
`endif

endmodule

@@ tb/mesh_flood_relay_filter_top_test.sv @@
// Self-checking testbench of the mesh flood relay filter: directed and random packet headers.
`timescale 1ns / 1ps
module mesh_flood_relay_filter_top_test;
  import mfr_pkg::*;

  localparam int unsigned SeenDepth  = SeenDepthDefault;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 215;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PoolSize   = 6;
  localparam int unsigned HistDepth  = 48;

  typedef struct {
    bit          is_write;
    cfg_reg_e    reg_idx;
    logic [15:0] reg_val;
    item_t       pkt;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mfr_stream_if #(.payload_t(item_t))    pkt_if ();
  mfr_stream_if #(.payload_t(result_t))  res_if ();
  mfr_stream_if #(.payload_t(cfg_req_t)) reg_if ();

  mesh_flood_relay_filter_top #(
    .SEEN_DEPTH(SeenDepth)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (pkt_if),
    .out_o (res_if),
    .cfg_i (reg_if)
  );

  logic [31:0] known_keys [SeenDepth];
  int unsigned next_slot;
  logic [15:0] own_id;
  logic        relay_en;
  logic [7:0]  restart_code;
  logic [7:0]  config_code;
  logic [7:0]  relay_mask;

  result_t     decisions_q [$];
  cfg_req_t    reg_batch [$];
  stim_row_t   script [$];
  logic [31:0] key_history [$];
  logic [15:0] id_pool [PoolSize];
  int unsigned mismatch_cnt;
  int unsigned burst_left;
  int unsigned cycle_cnt = 0;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void reset_shadow();
    int i;
    for (i = 0; i < SeenDepth; i++) known_keys[i] = '0;
    next_slot    = 0;
    own_id       = 16'h0000;
    relay_en     = 1'b1;
    restart_code = 8'h00;
    config_code  = 8'h01;
    relay_mask   = 8'h01;
  endfunction

  function automatic void latch_register(cfg_reg_e idx, logic [15:0] val);
    case (idx)
      REG_OWN_ID:       own_id       = val;
      REG_RELAY_MODE:   relay_en     = val[0];
      REG_RESTART_CODE: restart_code = val[7:0];
      REG_CONFIG_CODE:  config_code  = val[7:0];
      REG_RELAY_MASK:   relay_mask   = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic result_t predict_decision(item_t p);
    result_t     r;
    logic        addressed;
    logic [31:0] key;
    bit          hit;
    int          i;
    r = '0;
    addressed = (p.origin_node == own_id) || (p.origin_node == BroadcastId);
    if (addressed && p.packet_kind == restart_code) begin
      r.restart_request = 1'b1;
    end else begin
      if (addressed && p.packet_kind == config_code) begin
        r.config_update = 1'b1;
        if (p.sensor_field != 8'd0) begin
          r.pin_update = 1'b1;
          r.new_pin    = p.sensor_field;
        end
        r.new_enable = (p.spare_byte != 8'd0);
        if (p.distance_field >= 16'd1 && p.distance_field <= MaxDivider) begin
          r.divider_update = 1'b1;
          r.new_divider    = p.distance_field[3:0];
        end
      end
      if (relay_en && p.origin_node != own_id && p.hop_budget != 8'd0) begin
        key = {p.origin_node, p.sequence_req};
        hit = 1'b0;
        for (i = 0; i < SeenDepth; i++) begin
          if (known_keys[i] == key) hit = 1'b1;
        end
        if (!hit) begin
          known_keys[next_slot] = key;
          next_slot             = (next_slot + 1) % SeenDepth;
          r.forward             = 1'b1;
          r.forward_hops        = p.hop_budget - 8'd1;
          r.forward_flags       = p.packet_flags | relay_mask;
        end
      end
    end
    return r;
  endfunction

  function automatic void check_decision(result_t got);
    result_t want;
    if (decisions_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("unexpected decision: got %p", got);
    end else begin
      want = decisions_q.pop_front();
      if (got !== want) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("decision mismatch: expected %p, got %p", want, got);
      end
    end
  endfunction

  function automatic item_t hdr(logic [15:0] o, logic [15:0] s, logic [7:0] h, logic [7:0] k,
                                logic [7:0] f, logic [7:0] sn, logic [7:0] sp, logic [15:0] d);
    item_t p;
    p.origin_node    = o;
    p.sequence_req   = s;
    p.hop_budget     = h;
    p.packet_kind    = k;
    p.packet_flags   = f;
    p.sensor_field   = sn;
    p.spare_byte     = sp;
    p.distance_field = d;
    return p;
  endfunction

  function automatic result_t dec(logic fw, logic [7:0] fh, logic [7:0] ff, logic rs, logic cu,
                                  logic pu, logic [7:0] np, logic ne, logic du, logic [3:0] nd);
    result_t r;
    r.forward         = fw;
    r.forward_hops    = fh;
    r.forward_flags   = ff;
    r.restart_request = rs;
    r.config_update   = cu;
    r.pin_update      = pu;
    r.new_pin         = np;
    r.new_enable      = ne;
    r.divider_update  = du;
    r.new_divider     = nd;
    return r;
  endfunction

  function automatic void add_pkt(item_t p, bit typed, result_t want);
    stim_row_t row;
    row.is_write = 1'b0;
    row.reg_idx  = REG_OWN_ID;
    row.reg_val  = '0;
    row.pkt      = p;
    row.typed    = typed;
    row.want     = want;
    script.push_back(row);
  endfunction

  function automatic void add_write(cfg_reg_e idx, logic [15:0] val);
    stim_row_t row;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    row.pkt      = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    script.push_back(row);
  endfunction

  function automatic void build_script();
    result_t none;
    result_t restart;
    none    = '0;
    restart = dec(0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_pkt(hdr(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000), 1, restart);
    add_pkt(hdr(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), 1, restart);
    add_pkt(hdr(16'h0000, 16'h0005, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, 16'h0000), 1,
            dec(0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    add_pkt(hdr(16'h0000, 16'h0006, 8'h03, 8'h01, 8'h00, 8'hFF, 8'hFF, 16'h0008), 1,
            dec(0, 0, 0, 0, 1, 1, 8'hFF, 1, 1, 4'd8));
    add_pkt(hdr(16'h0000, 16'h0007, 8'h03, 8'h01, 8'h00, 8'h01, 8'h01, 16'h0001), 1,
            dec(0, 0, 0, 0, 1, 1, 8'h01, 1, 1, 4'd1));
    add_pkt(hdr(16'h0000, 16'h0008, 8'h03, 8'h01, 8'h00, 8'h00, 8'h80, 16'h0009), 1,
            dec(0, 0, 0, 0, 1, 0, 0, 1, 0, 0));
    add_pkt(hdr(16'hFFFF, 16'h0001, 8'h05, 8'h01, 8'h80, 8'h00, 8'h00, 16'hFFFF), 1,
            dec(1, 8'h04, 8'h81, 0, 1, 0, 0, 0, 0, 0));
    add_pkt(hdr(16'hFFFF, 16'h0001, 8'h05, 8'h01, 8'h80, 8'h00, 8'h00, 16'hFFFF), 0, none);
    add_pkt(hdr(16'h1234, 16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000), 1,
            dec(1, 8'hFE, 8'h01, 0, 0, 0, 0, 0, 0, 0));
    add_pkt(hdr(16'h1234, 16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000), 0, none);
    add_pkt(hdr(16'h4321, 16'h0001, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 16'h0000), 1, none);
    add_pkt(hdr(16'h4321, 16'h0002, 8'h01, 8'h02, 8'hFE, 8'h00, 8'h00, 16'h0000), 1,
            dec(1, 8'h00, 8'hFF, 0, 0, 0, 0, 0, 0, 0));
    add_write(REG_OWN_ID, 16'h1234);
    add_pkt(hdr(16'h0000, 16'h0000, 8'h09, 8'h05, 8'h00, 8'h00, 8'h00, 16'h0000), 0, none);
    add_pkt(hdr(16'h1234, 16'h0003, 8'h09, 8'h01, 8'h00, 8'h10, 8'h00, 16'h0003), 0, none);
    add_write(REG_RESTART_CODE, 16'h0007);
    add_write(REG_CONFIG_CODE, 16'h0007);
    add_pkt(hdr(16'hFFFF, 16'h0009, 8'h09, 8'h07, 8'h00, 8'h00, 8'h00, 16'h0000), 1, restart);
    add_write(REG_RELAY_MASK, 16'h00FF);
    add_pkt(hdr(16'h5555, 16'hAAAA, 8'h80, 8'h03, 8'h55, 8'h00, 8'h00, 16'h0000), 0, none);
    add_write(REG_RELAY_MASK, 16'h0000);
    add_pkt(hdr(16'hAAAA, 16'h5555, 8'h02, 8'h03, 8'hAA, 8'h00, 8'h00, 16'h0000), 0, none);
    add_write(REG_RELAY_MODE, 16'h0000);
    add_pkt(hdr(16'h2222, 16'h0001, 8'h09, 8'h03, 8'h00, 8'h00, 8'h00, 16'h0000), 1, none);
    add_pkt(hdr(16'hFFFF, 16'h0002, 8'h09, 8'h07, 8'h00, 8'h00, 8'h00, 16'h0000), 1, restart);
  endfunction

  function automatic item_t random_pkt();
    item_t       p;
    int unsigned r;
    logic [31:0] key;
    r = $urandom_range(0, 99);
    if (r < 12) p.origin_node = own_id;
    else if (r < 24) p.origin_node = BroadcastId;
    else if (r < 70) p.origin_node = id_pool[$urandom_range(0, PoolSize - 1)];
    else if (r < 75) p.origin_node = 16'h0000;
    else p.origin_node = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40) p.sequence_req = 16'($urandom_range(0, 15));
    else if (r < 50) p.sequence_req = 16'h0000;
    else if (r < 60) p.sequence_req = 16'hFFFF;
    else p.sequence_req = 16'($urandom);
    if (key_history.size() != 0 && $urandom_range(0, 3) == 0) begin
      key = key_history[$urandom_range(0, key_history.size() - 1)];
      p.origin_node  = key[31:16];
      p.sequence_req = key[15:0];
    end
    key_history.push_back({p.origin_node, p.sequence_req});
    if (key_history.size() > HistDepth) void'(key_history.pop_front());
    r = $urandom_range(0, 99);
    if (r < 10) p.hop_budget = 8'h00;
    else if (r < 20) p.hop_budget = 8'h01;
    else if (r < 30) p.hop_budget = 8'hFF;
    else p.hop_budget = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 15) p.packet_kind = restart_code;
    else if (r < 35) p.packet_kind = config_code;
    else p.packet_kind = 8'($urandom);
    p.packet_flags = 8'($urandom);
    p.sensor_field = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
    p.spare_byte   = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40) p.distance_field = 16'($urandom_range(0, 9));
    else if (r < 50) p.distance_field = 16'hFFFF;
    else p.distance_field = 16'($urandom);
    return p;
  endfunction

  task automatic queue_write(cfg_reg_e idx, logic [15:0] val);
    cfg_req_t w;
    w.index = idx;
    w.data  = val;
    reg_batch.push_back(w);
  endtask

  task automatic write_regs();
    int k;
    for (k = 0; k < reg_batch.size(); k++) begin
      reg_if.valid   <= 1'b1;
      reg_if.payload <= reg_batch[k];
      do @(posedge clk); while (!reg_if.ready);
      latch_register(cfg_reg_e'(reg_batch[k].index), reg_batch[k].data);
    end
    reg_if.valid <= 1'b0;
    reg_batch.delete();
  endtask

  task automatic drain();
    do @(posedge clk); while (decisions_q.size() != 0);
  endtask

  task automatic send_pkt(item_t p, bit typed, result_t want);
    int unsigned gap;
    result_t     r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        pkt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pkt_if.valid   <= 1'b1;
    pkt_if.payload <= p;
    do @(posedge clk); while (!pkt_if.ready);
    r = predict_decision(p);
    decisions_q.push_back(typed ? want : r);
  endtask

  initial begin
    int unsigned rcv_cnt;
    int unsigned stall_left;
    logic [15:0] pattern;
    res_if.ready = 1'b0;
    rcv_cnt      = 0;
    stall_left   = 0;
    pattern      = 16'hFFFF;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) check_decision(res_if.payload);
      rcv_cnt++;
      if (rcv_cnt % 64 == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
      end
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        stall_left   = HoldCycles;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= rst_n & pattern[rcv_cnt % 16];
      end
    end
  end

  initial begin
    int        i;
    int        n;
    int        ph;
    stim_row_t row;
    rst_n          = 1'b0;
    pkt_if.valid   = 1'b0;
    pkt_if.payload = '0;
    reg_if.valid   = 1'b0;
    reg_if.payload = '0;
    hold_req       = 1'b0;
    burst_left     = 0;
    mismatch_cnt   = 0;
    reset_shadow();
    for (i = 0; i < PoolSize; i++) id_pool[i] = 16'($urandom);
    build_script();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      if (row.is_write) begin
        pkt_if.valid <= 1'b0;
        drain();
        queue_write(row.reg_idx, row.reg_val);
        write_regs();
      end else begin
        send_pkt(row.pkt, row.typed, row.want);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      pkt_if.valid <= 1'b0;
      drain();
      case (ph)
        0: begin
          queue_write(REG_OWN_ID, 16'h0000);
          queue_write(REG_RELAY_MODE, 16'h0001);
          queue_write(REG_RESTART_CODE, 16'h0000);
          queue_write(REG_CONFIG_CODE, 16'h0001);
          queue_write(REG_RELAY_MASK, 16'h0001);
        end
        1: begin
          queue_write(REG_OWN_ID, 16'hFFFF);
          queue_write(REG_RELAY_MODE, 16'h0001);
          queue_write(REG_RESTART_CODE, 16'h00FF);
          queue_write(REG_CONFIG_CODE, 16'h0000);
          queue_write(REG_RELAY_MASK, 16'h00FF);
        end
        2, 3: begin
          queue_write(REG_OWN_ID, 16'($urandom));
          queue_write(REG_RELAY_MODE, (ph == 2) ? 16'h0001 : 16'h0000);
          queue_write(REG_RESTART_CODE, 16'($urandom_range(0, 255)));
          queue_write(REG_CONFIG_CODE, 16'($urandom_range(0, 255)));
          queue_write(REG_RELAY_MASK, 16'($urandom_range(0, 255)));
        end
        4: begin
          queue_write(REG_OWN_ID, 16'h0001);
          queue_write(REG_RELAY_MODE, 16'h0001);
          queue_write(REG_RESTART_CODE, 16'h0005);
          queue_write(REG_CONFIG_CODE, 16'h0005);
          queue_write(REG_RELAY_MASK, 16'h0000);
        end
        default: begin
          queue_write(REG_OWN_ID, 16'($urandom));
          queue_write(REG_RELAY_MODE, 16'($urandom) | 16'h0001);
          queue_write(REG_RESTART_CODE, 16'($urandom));
          queue_write(REG_CONFIG_CODE, 16'($urandom));
          queue_write(REG_RELAY_MASK, 16'($urandom));
        end
      endcase
      write_regs();
      for (n = 0; n < PhaseItems; n++) begin
        if (ph == 2 && n == 60) hold_req = 1'b1;
        send_pkt(random_pkt(), 1'b0, '0);
      end
    end

    pkt_if.valid <= 1'b0;
    drain();
    repeat (SeenDepth + 8) @(posedge clk);
    if (mismatch_cnt == 0 && decisions_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mfr_pkg.sv
rtl/mfr_stream_if.sv
rtl/mfr_seen_cell.sv
rtl/mesh_flood_relay_filter_top.sv
tb/mesh_flood_relay_filter_top_test.sv
